>>> rtl/vst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vst_pkg
// Shared types and constants of the voxel segment traversal core.
// ----------------------------------------------------------------------------
package vst_pkg;

  // Default parameter values of the top level.
  localparam int MAX_CROSSINGS_DEF = 16;
  localparam int COORD_WIDTH_DEF   = 32;

  // Shared divider and multiplier widths.
  localparam int DIV_W   = 64;
  localparam int MUL_A_W = 30;
  localparam int MUL_B_W = 31;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int T_FRAC  = 30;

  // Configuration port.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_CELL_X = 2'd0;
  localparam logic [1:0] REG_CELL_Y = 2'd1;
  localparam logic [1:0] REG_CELL_Z = 2'd2;
  localparam logic [CFG_DATA_W-1:0] CELL_RESET = 32'd65536;

  // Parametric fixed point: 1.0 and the saturation cap.
  localparam logic [63:0] T_ONE = 64'h0000_0000_4000_0000;
  localparam logic [63:0] T_CAP = 64'h4000_0000_0000_0000;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT_START,
    ST_SELECT,
    ST_MUL_ISSUE,
    ST_MUL_WAIT,
    ST_EMIT_CROSS,
    ST_EMIT_END
  } vst_state_e;

  // Division performed during setup of one axis.
  typedef enum logic [1:0] {
    DOP_CUR,
    DOP_FIN,
    DOP_T,
    DOP_DT
  } div_op_e;

  // Divider request and response.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             busy;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

>>> rtl/vst_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vst_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vst_div import vst_pkg::*; #(
  parameter int WIDTH = DIV_W
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(WIDTH);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [WIDTH-1:0] rem_q, quo_q, den_q;
  logic [WIDTH:0]   shifted;
  logic             fits;

  // One trial subtraction per cycle.
  assign shifted = {rem_q, quo_q[WIDTH-1]};
  assign fits    = shifted >= {1'b0, den_q};

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(WIDTH - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the numerator shifts out as the quotient shifts in.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[WIDTH-2:0], fits};
      rem_q <= fits ? WIDTH'(shifted - {1'b0, den_q}) : shifted[WIDTH-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = busy_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

>>> rtl/vst_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vst_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module vst_mul import vst_pkg::*; (
  input  logic               clk_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic [MUL_P_W-1:0] p_o
);

  logic [MUL_P_W-1:0] p_q;

  // Product register, ready in the cycle after the operands.
  always_ff @(posedge clk_i) begin
    p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
  end

  assign p_o = p_q;

endmodule

>>> rtl/voxel_segment_traversal_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_segment_traversal_core
// 3D DDA walk of a segment through a cell grid: start, each crossing, end point.
// ----------------------------------------------------------------------------
// Setup takes 6 to 12 divisions on the shared divider before the start point
// item. Each crossing then takes selection plus six passes through the
// shared multiplier. One segment is worked on at a time; the next is taken
// once the end point item is loaded into the output register.
// Reset is asynchronous and active low; it clears control state and sets
// all cell sizes to 1.0.
module voxel_segment_traversal_core import vst_pkg::*; #(
  parameter int MAX_CROSSINGS = MAX_CROSSINGS_DEF,
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [CFG_ADDR_W-1:0]         paddr,
  input  logic [CFG_DATA_W-1:0]         pwdata,
  output logic [CFG_DATA_W-1:0]         prdata,
  output logic                          pready,
  // Segment input.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] start_x_i,
  input  logic signed [COORD_WIDTH-1:0] start_y_i,
  input  logic signed [COORD_WIDTH-1:0] start_z_i,
  input  logic signed [COORD_WIDTH-1:0] end_x_i,
  input  logic signed [COORD_WIDTH-1:0] end_y_i,
  input  logic signed [COORD_WIDTH-1:0] end_z_i,
  // Point output.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] point_x_o,
  output logic signed [COORD_WIDTH-1:0] point_y_o,
  output logic signed [COORD_WIDTH-1:0] point_z_o,
  output logic                          is_last_o,
  output logic                          truncated_o
);

  localparam int W      = COORD_WIDTH;
  localparam int CELL_W = COORD_WIDTH + 2;
  localparam int K_W    = $clog2(MAX_CROSSINGS + 1);

  // ------------------------------------------------------------------------
  // Configuration registers.
  logic [CFG_DATA_W-1:0] cfg_q [3];
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[0] <= CELL_RESET;
      cfg_q[1] <= CELL_RESET;
      cfg_q[2] <= CELL_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CELL_X: cfg_q[0] <= pwdata;
        REG_CELL_Y: cfg_q[1] <= pwdata;
        REG_CELL_Z: cfg_q[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CELL_X: prdata = cfg_q[0];
      REG_CELL_Y: prdata = cfg_q[1];
      REG_CELL_Z: prdata = cfg_q[2];
      default:    prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------------
  // Segment state.
  vst_state_e               state_q, state_d;
  div_op_e                  dop_q;
  logic [1:0]               axis_q;
  logic [K_W-1:0]           k_q;
  logic [2:0]               mstep_q;
  logic signed [W-1:0]      p0_q [3];
  logic signed [W-1:0]      p1_q [3];
  logic signed [W-1:0]      pt_q [3];
  logic [31:0]              size_q [3];
  logic [W:0]               adir_q [3];
  logic                     dneg_q [3];
  logic signed [CELL_W-1:0] cur_q [3];
  logic signed [CELL_W-1:0] fin_q [3];
  logic [63:0]              tt_q [3];
  logic [63:0]              dt_q [3];
  logic [33:0]              r_q;
  logic [63:0]              off_q;
  logic [MUL_B_W-1:0]       t_q;

  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_P_W-1:0] mul_p;

  vst_div #(.WIDTH(DIV_W)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  vst_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (t_q),
    .p_o   (mul_p)
  );

  // ------------------------------------------------------------------------
  // Divider operands for the current axis and setup step.
  logic signed [W:0] pos_w;
  logic [W:0]        pos_abs;
  logic              pos_neg;
  logic [33:0]       bnd_dist;
  logic              last_op;

  always_comb begin
    pos_w   = (dop_q == DOP_FIN) ? {p1_q[axis_q][W-1], p1_q[axis_q]}
                                 : {p0_q[axis_q][W-1], p0_q[axis_q]};
    pos_neg = pos_w[W];
    pos_abs = pos_neg ? (W+1)'(-pos_w) : pos_w;
    // Distance to the first boundary in half units, from the rounding remainder.
    bnd_dist = ((!dneg_q[axis_q]) ^ p0_q[axis_q][W-1])
               ? (34'(size_q[axis_q]) << 1) - r_q : r_q;
    last_op = (dop_q == DOP_DT) || (dop_q == DOP_FIN && adir_q[axis_q] == '0);

    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    case (dop_q)
      DOP_CUR, DOP_FIN: begin
        div_req.num = (64'(pos_abs) << 1) + 64'(size_q[axis_q]);
        div_req.den = 64'(size_q[axis_q]) << 1;
      end
      DOP_T: begin
        div_req.num = 64'(bnd_dist) << 29;
        div_req.den = 64'(adir_q[axis_q]);
      end
      DOP_DT: begin
        div_req.num = 64'(size_q[axis_q]) << T_FRAC;
        div_req.den = 64'(adir_q[axis_q]);
      end
      default: ;
    endcase
    if (state_q == ST_DIV_START) div_req.start = 1'b1;
  end

  // Signed cell index from the quotient.
  logic signed [CELL_W-1:0] cell_val;
  assign cell_val = pos_neg ? -CELL_W'(div_rsp.quo) : CELL_W'(div_rsp.quo);

  // ------------------------------------------------------------------------
  // Next crossing: smallest t among unfinished axes, ties to z, then y.
  logic [2:0]  act;
  logic        any_act;
  logic [1:0]  best;
  logic [63:0] tbest;
  logic [64:0] tsum;
  logic [63:0] tnext;
  logic        trunc;

  always_comb begin
    for (int a = 0; a < 3; a++) act[a] = cur_q[a] != fin_q[a];
    any_act = |act;
    best    = 2'd0;
    tbest   = tt_q[0];
    if (act[1] && (!act[0] || tt_q[1] <= tbest)) begin
      best  = 2'd1;
      tbest = tt_q[1];
    end
    if (act[2] && (!(act[0] || act[1]) || tt_q[2] <= tbest)) begin
      best  = 2'd2;
      tbest = tt_q[2];
    end
    tsum  = {1'b0, tbest} + {1'b0, dt_q[best]};
    tnext = (tsum > {1'b0, T_CAP}) ? T_CAP : tsum[63:0];
    trunc = any_act;
  end

  // ------------------------------------------------------------------------
  // Crossing point offset: high and low parts of |dir| times t.
  logic [1:0]         max_ax;
  logic               mhalf;
  logic [63:0]        adir64;
  logic [63:0]        off_sum;
  logic signed [63:0] p0_ext;
  logic [63:0]        pt_sum;

  always_comb begin
    max_ax  = mstep_q[2:1];
    mhalf   = mstep_q[0];
    adir64  = 64'(adir_q[max_ax]);
    mul_a   = mhalf ? adir64[MUL_A_W-1:0] : adir64[2*MUL_A_W-1:MUL_A_W];
    off_sum = off_q + 64'(mul_p >> T_FRAC);
    p0_ext  = 64'(p0_q[max_ax]);
    pt_sum  = dneg_q[max_ax] ? 64'(p0_ext - $signed(off_sum))
                             : 64'(p0_ext + $signed(off_sum));
  end

  // ------------------------------------------------------------------------
  // Sequencer.
  logic slot_free;
  logic out_load;
  assign slot_free = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = ST_DIV_START;
      end
      ST_DIV_START: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          if (last_op && axis_q == 2'd2) state_d = ST_EMIT_START;
          else state_d = ST_DIV_START;
        end
      end
      ST_EMIT_START: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = ST_SELECT;
        end
      end
      ST_SELECT: begin
        if (!any_act || k_q == K_W'(MAX_CROSSINGS)) state_d = ST_EMIT_END;
        else state_d = ST_MUL_ISSUE;
      end
      ST_MUL_ISSUE: state_d = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mstep_q == 3'd5) state_d = ST_EMIT_CROSS;
        else state_d = ST_MUL_ISSUE;
      end
      ST_EMIT_CROSS: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = ST_SELECT;
        end
      end
      ST_EMIT_END: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dop_q   <= DOP_CUR;
      axis_q  <= 2'd0;
      k_q     <= '0;
      mstep_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          dop_q  <= DOP_CUR;
          axis_q <= 2'd0;
          k_q    <= '0;
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            if (last_op) begin
              dop_q  <= DOP_CUR;
              axis_q <= axis_q + 2'd1;
            end else begin
              dop_q <= div_op_e'(dop_q + 2'd1);
            end
          end
        end
        ST_SELECT: begin
          mstep_q <= '0;
          if (any_act && k_q != K_W'(MAX_CROSSINGS)) k_q <= k_q + 1'b1;
        end
        ST_MUL_WAIT: mstep_q <= mstep_q + 3'd1;
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          p0_q[0] <= start_x_i;
          p0_q[1] <= start_y_i;
          p0_q[2] <= start_z_i;
          p1_q[0] <= end_x_i;
          p1_q[1] <= end_y_i;
          p1_q[2] <= end_z_i;
          for (int a = 0; a < 3; a++) begin
            size_q[a] <= (cfg_q[a] == '0) ? 32'd1 : cfg_q[a];
            tt_q[a]   <= '0;
            dt_q[a]   <= '0;
          end
          begin : dir_calc
            logic signed [W:0] d [3];
            d[0] = {end_x_i[W-1], end_x_i} - {start_x_i[W-1], start_x_i};
            d[1] = {end_y_i[W-1], end_y_i} - {start_y_i[W-1], start_y_i};
            d[2] = {end_z_i[W-1], end_z_i} - {start_z_i[W-1], start_z_i};
            for (int a = 0; a < 3; a++) begin
              dneg_q[a] <= d[a][W];
              adir_q[a] <= d[a][W] ? (W+1)'(-d[a]) : d[a];
            end
          end
        end
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          case (dop_q)
            DOP_CUR: begin
              cur_q[axis_q] <= cell_val;
              r_q           <= div_rsp.rem[33:0];
            end
            DOP_FIN: fin_q[axis_q] <= cell_val;
            DOP_T:   tt_q[axis_q]  <= div_rsp.quo;
            DOP_DT:  dt_q[axis_q]  <= div_rsp.quo;
            default: ;
          endcase
        end
      end
      ST_SELECT: begin
        if (any_act && k_q != K_W'(MAX_CROSSINGS)) begin
          cur_q[best] <= dneg_q[best] ? cur_q[best] - 1'b1 : cur_q[best] + 1'b1;
          tt_q[best]  <= tnext;
          t_q         <= (tbest > T_ONE) ? MUL_B_W'(T_ONE) : tbest[MUL_B_W-1:0];
        end
      end
      ST_MUL_WAIT: begin
        if (!mhalf) off_q <= 64'(mul_p);
        else pt_q[max_ax] <= pt_sum[W-1:0];
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      case (state_q)
        ST_EMIT_START: begin
          point_x_o   <= p0_q[0];
          point_y_o   <= p0_q[1];
          point_z_o   <= p0_q[2];
          is_last_o   <= 1'b0;
          truncated_o <= 1'b0;
        end
        ST_EMIT_CROSS: begin
          point_x_o   <= pt_q[0];
          point_y_o   <= pt_q[1];
          point_z_o   <= pt_q[2];
          is_last_o   <= 1'b0;
          truncated_o <= 1'b0;
        end
        default: begin
          point_x_o   <= p1_q[0];
          point_y_o   <= p1_q[1];
          point_z_o   <= p1_q[2];
          is_last_o   <= 1'b1;
          truncated_o <= trunc;
        end
      endcase
    end
  end

  // ------------------------------------------------------------------------
  // Assertions.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("block ready right after taking an item");

  a_trunc_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && truncated_o |-> is_last_o)
    else $error("truncated flag on a non-final item");

  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= K_W'(MAX_CROSSINGS))
    else $error("crossing count past limit");

  a_div_idle_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SELECT |-> !div_rsp.busy)
    else $error("divider busy during the walk");

endmodule
